[design/event_stream_line_parser_assert.svh]
// assertion helpers for the event stream line parser
`ifndef EVENT_STREAM_LINE_PARSER_ASSERT_SVH
`define EVENT_STREAM_LINE_PARSER_ASSERT_SVH

// same-cycle implication, ignored while reset is held
`define ESLP_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, ignored while reset is held
`define ESLP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/eslp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// eslp_pkg
// Shared constants, types and helper functions of the event stream parser.
// ----------------------------------------------------------------------------
package eslp_pkg;

    localparam int LINE_MAX    = 1024;
    localparam int EVENT_MAX   = 32;
    localparam int LINE_CNT_W  = $clog2(LINE_MAX);
    localparam int NAME_LEN_W  = $clog2(EVENT_MAX);
    localparam int NAME_ADDR_W = $clog2(EVENT_MAX - 1);
    localparam int NAME_DEPTH  = EVENT_MAX - 1;
    localparam int DLEN_W      = 24;
    localparam int Q_DEPTH     = 2;
    localparam int Q_PTR_W     = $clog2(Q_DEPTH);
    localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

    localparam logic [LINE_CNT_W-1:0] LINE_CNT_LAST = LINE_CNT_W'(LINE_MAX - 1);
    localparam logic [NAME_LEN_W-1:0] NAME_LEN_LAST = NAME_LEN_W'(EVENT_MAX - 1);
    localparam logic [NAME_LEN_W-1:0] MSG_IDX_LAST  = NAME_LEN_W'(6);
    localparam logic [DLEN_W-1:0]     DLEN_MAX      = {DLEN_W{1'b1}};

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_E     = 8'h65;

    localparam logic [2:0] MATCH_FAIL     = 3'd7;
    localparam logic [2:0] DATA_NAME_LEN  = 3'd4;
    localparam logic [2:0] EVENT_NAME_LEN = 3'd5;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_NAME = 2'd1,
        KIND_END  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        FK_NONE  = 2'd0,
        FK_DATA  = 2'd1,
        FK_EVENT = 2'd2
    } t_field;

    typedef enum logic {
        OP_DATA     = 1'b0,
        OP_DISPATCH = 1'b1
    } t_op;

    // one queued job: a data byte, a line feed, a line feed then a data byte, or a dispatch
    typedef struct packed {
        t_op                   op;
        logic                  pre_nl;
        logic                  has_byte;
        logic [7:0]            data;
        logic [NAME_LEN_W-1:0] name_len;
        logic [DLEN_W-1:0]     total;
    } t_cmd;

    function automatic logic [7:0] data_char(input logic [1:0] idx);
        logic [7:0] ch;
        case (idx)
            2'd0:    ch = 8'h64;
            2'd1:    ch = 8'h61;
            2'd2:    ch = 8'h74;
            default: ch = 8'h61;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] event_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = 8'h65;
            3'd1:    ch = 8'h76;
            3'd2:    ch = 8'h65;
            3'd3:    ch = 8'h6E;
            default: ch = 8'h74;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] msg_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = 8'h6D;
            3'd1:    ch = 8'h65;
            3'd2:    ch = 8'h73;
            3'd3:    ch = 8'h73;
            3'd4:    ch = 8'h61;
            3'd5:    ch = 8'h67;
            default: ch = 8'h65;
        endcase
        return ch;
    endfunction

    function automatic logic [DLEN_W-1:0] sat_inc(input logic [DLEN_W-1:0] x);
        return (x == DLEN_MAX) ? x : x + DLEN_W'(1);
    endfunction

endpackage
`default_nettype wire

[design/eslp_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// eslp_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module eslp_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

[design/eslp_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// eslp_front
// Line parser: takes one raw byte per cycle while o_ready is high, tracks the
// field name and value, stores the event name, queues data and dispatch jobs.
// ----------------------------------------------------------------------------
module eslp_front import eslp_pkg::*; (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    input  wire logic [7:0]             i_byte_req,
    output logic                        o_ready,
    input  wire logic                   i_q_full,
    output logic                        o_q_push,
    output t_cmd                        o_q_cmd,
    output logic                        o_we,
    output logic [NAME_ADDR_W-1:0]      o_waddr,
    output logic [7:0]                  o_wdata,
    input  wire logic                   i_disp_done,
    output logic                        o_busy
);

    typedef enum logic [3:0] {
        PH_START   = 4'b0001,
        PH_NAME    = 4'b0010,
        PH_VALUE   = 4'b0100,
        PH_COMMENT = 4'b1000
    } t_phase;

    t_phase                r_phase, n_phase;
    logic [LINE_CNT_W-1:0] r_line_count, n_line_count;
    logic [2:0]            r_match, n_match;
    t_field                r_field, n_field;
    logic                  r_value_started, n_value_started;
    logic                  r_saw_field, n_saw_field;
    logic                  r_pending_nl, n_pending_nl;
    logic [NAME_LEN_W-1:0] r_event_len, n_event_len;
    logic [DLEN_W-1:0]     r_total, n_total;
    logic                  r_busy, n_busy;

    logic                  accept;
    t_field                fk_fin;
    logic [DLEN_W-1:0]     tot_pre;

    assign o_ready = !i_q_full && !r_busy;
    assign o_busy  = r_busy;
    assign accept  = i_valid && o_ready;

    // field kind once the name is complete: only an exact match survives
    assign fk_fin = ((r_field == FK_DATA && r_match == DATA_NAME_LEN) ||
                     (r_field == FK_EVENT && r_match == EVENT_NAME_LEN)) ? r_field : FK_NONE;
    assign tot_pre = r_pending_nl ? sat_inc(r_total) : r_total;

    always_comb begin
        n_phase         = r_phase;
        n_line_count    = r_line_count;
        n_match         = r_match;
        n_field         = r_field;
        n_value_started = r_value_started;
        n_saw_field     = r_saw_field;
        n_pending_nl    = r_pending_nl;
        n_event_len     = r_event_len;
        n_total         = r_total;
        n_busy          = r_busy;
        o_q_push        = 1'b0;
        o_q_cmd         = '{op: OP_DATA, pre_nl: 1'b0, has_byte: 1'b0, data: i_byte_req,
                            name_len: r_event_len, total: r_total};
        o_we            = 1'b0;
        o_waddr         = r_event_len[NAME_ADDR_W-1:0];
        o_wdata         = i_byte_req;

        if (i_disp_done) begin
            n_busy = 1'b0;
        end

        if (accept && i_byte_req != CH_CR) begin
            if (i_byte_req == CH_LF) begin
                if (r_phase == PH_START) begin
                    // blank line closes the event
                    if (r_saw_field) begin
                        o_q_push     = 1'b1;
                        o_q_cmd.op   = OP_DISPATCH;
                        n_busy       = 1'b1;
                        n_event_len  = '0;
                        n_total      = '0;
                        n_pending_nl = 1'b0;
                        n_saw_field  = 1'b0;
                    end
                end else if (r_phase != PH_COMMENT) begin
                    n_saw_field = 1'b1;
                    if (r_phase == PH_NAME && fk_fin == FK_EVENT) begin
                        n_event_len = '0;
                    end
                    if ((r_phase == PH_NAME ? fk_fin : r_field) == FK_DATA) begin
                        if (r_pending_nl) begin
                            o_q_push       = 1'b1;
                            o_q_cmd.pre_nl = 1'b1;
                            n_total        = sat_inc(r_total);
                        end
                        n_pending_nl = 1'b1;
                    end
                end
                n_phase         = PH_START;
                n_line_count    = '0;
                n_match         = '0;
                n_field         = FK_NONE;
                n_value_started = 1'b0;
            end else if (r_line_count != LINE_CNT_LAST) begin
                n_line_count = r_line_count + LINE_CNT_W'(1);
                case (r_phase)
                    PH_START: begin
                        if (i_byte_req == CH_COLON) begin
                            n_phase = PH_COMMENT;
                        end else begin
                            n_phase = PH_NAME;
                            if (i_byte_req == CH_D) begin
                                n_field = FK_DATA;
                                n_match = 3'd1;
                            end else if (i_byte_req == CH_E) begin
                                n_field = FK_EVENT;
                                n_match = 3'd1;
                            end else begin
                                n_field = FK_NONE;
                                n_match = MATCH_FAIL;
                            end
                        end
                    end
                    PH_NAME: begin
                        if (i_byte_req == CH_COLON) begin
                            n_field         = fk_fin;
                            n_phase         = PH_VALUE;
                            n_value_started = 1'b0;
                            if (fk_fin == FK_EVENT) begin
                                n_event_len = '0;
                            end
                        end else if (r_match != MATCH_FAIL) begin
                            if (r_field == FK_DATA && r_match < DATA_NAME_LEN &&
                                i_byte_req == data_char(r_match[1:0])) begin
                                n_match = r_match + 3'd1;
                            end else if (r_field == FK_EVENT && r_match < EVENT_NAME_LEN &&
                                         i_byte_req == event_char(r_match)) begin
                                n_match = r_match + 3'd1;
                            end else begin
                                n_match = MATCH_FAIL;
                            end
                        end
                    end
                    PH_VALUE: begin
                        n_value_started = 1'b1;
                        // one leading space of the value is skipped
                        if (r_value_started || i_byte_req != CH_SPACE) begin
                            if (r_field == FK_DATA) begin
                                o_q_push         = 1'b1;
                                o_q_cmd.pre_nl   = r_pending_nl;
                                o_q_cmd.has_byte = 1'b1;
                                n_total          = sat_inc(tot_pre);
                                n_pending_nl     = 1'b0;
                            end else if (r_field == FK_EVENT &&
                                         r_event_len != NAME_LEN_LAST) begin
                                o_we        = 1'b1;
                                n_event_len = r_event_len + NAME_LEN_W'(1);
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_START;
            r_line_count    <= '0;
            r_match         <= '0;
            r_field         <= FK_NONE;
            r_value_started <= 1'b0;
            r_saw_field     <= 1'b0;
            r_pending_nl    <= 1'b0;
            r_event_len     <= '0;
            r_total         <= '0;
            r_busy          <= 1'b0;
        end else begin
            r_phase         <= n_phase;
            r_line_count    <= n_line_count;
            r_match         <= n_match;
            r_field         <= n_field;
            r_value_started <= n_value_started;
            r_saw_field     <= n_saw_field;
            r_pending_nl    <= n_pending_nl;
            r_event_len     <= n_event_len;
            r_total         <= n_total;
            r_busy          <= n_busy;
        end
    end

endmodule
`default_nettype wire

[design/eslp_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// eslp_queue
// Short job queue between the line parser and the output sequencer.
// ----------------------------------------------------------------------------
module eslp_queue import eslp_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    input  wire logic i_pop,
    output t_cmd      o_head,
    output logic      o_full,
    output logic      o_empty
);

    t_cmd               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wptr, n_wptr;
    logic [Q_PTR_W-1:0] r_rptr, n_rptr;
    logic [Q_CNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rptr];

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wptr + Q_PTR_W'(1);
        end
        if (i_pop) begin
            n_rptr = (r_rptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rptr + Q_PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + Q_CNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - Q_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

endmodule
`default_nettype wire

[design/eslp_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// eslp_back
// Output sequencer: expands queued jobs into result words and drives the
// registered output stage.
// ----------------------------------------------------------------------------
module eslp_back import eslp_pkg::*; (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_cmd                   i_q_head,
    input  wire logic                   i_q_empty,
    output logic                        o_q_pop,
    output logic                        o_re,
    output logic [NAME_ADDR_W-1:0]      o_raddr,
    input  wire logic [7:0]             i_rdata,
    output logic                        o_disp_done,
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output logic [1:0]                  o_kind,
    output logic [7:0]                  o_value,
    output logic [DLEN_W-1:0]           o_data_length,
    output logic                        o_last
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_NL   = 7'b0000010,
        S_BYTE = 7'b0000100,
        S_MSG  = 7'b0001000,
        S_RD   = 7'b0010000,
        S_NAME = 7'b0100000,
        S_END  = 7'b1000000
    } t_state;

    t_state                r_state, n_state;
    t_cmd                  r_cmd, n_cmd;
    logic [NAME_LEN_W-1:0] r_idx, n_idx;

    logic                  r_o_valid, n_o_valid;
    t_kind                 r_kind, e_kind;
    logic [7:0]            r_value, e_value;
    logic [DLEN_W-1:0]     r_len, e_len;
    logic                  r_last, e_last;

    logic                  out_free;
    logic                  emit;

    assign out_free = !r_o_valid || i_ready;
    assign o_raddr  = r_idx[NAME_ADDR_W-1:0];

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_idx       = r_idx;
        o_q_pop     = 1'b0;
        o_re        = 1'b0;
        o_disp_done = 1'b0;
        emit        = 1'b0;
        e_kind      = KIND_DATA;
        e_value     = 8'd0;
        e_len       = '0;
        e_last      = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_cmd   = i_q_head;
                    n_idx   = '0;
                    if (i_q_head.op == OP_DATA) begin
                        n_state = i_q_head.pre_nl ? S_NL : S_BYTE;
                    end else begin
                        n_state = (i_q_head.name_len == '0) ? S_MSG : S_RD;
                    end
                end
            end
            S_NL: begin
                if (out_free) begin
                    emit    = 1'b1;
                    e_value = CH_LF;
                    e_last  = !r_cmd.has_byte;
                    n_state = r_cmd.has_byte ? S_BYTE : S_IDLE;
                end
            end
            S_BYTE: begin
                if (out_free) begin
                    emit    = 1'b1;
                    e_value = r_cmd.data;
                    e_last  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_MSG: begin
                // empty event name falls back to the default type
                if (out_free) begin
                    emit    = 1'b1;
                    e_kind  = KIND_NAME;
                    e_value = msg_char(r_idx[2:0]);
                    if (r_idx == MSG_IDX_LAST) begin
                        n_state = S_END;
                    end else begin
                        n_idx = r_idx + NAME_LEN_W'(1);
                    end
                end
            end
            S_RD: begin
                o_re    = 1'b1;
                n_state = S_NAME;
            end
            S_NAME: begin
                if (out_free) begin
                    emit    = 1'b1;
                    e_kind  = KIND_NAME;
                    e_value = i_rdata;
                    if (r_idx == r_cmd.name_len - NAME_LEN_W'(1)) begin
                        n_state = S_END;
                    end else begin
                        n_idx   = r_idx + NAME_LEN_W'(1);
                        n_state = S_RD;
                    end
                end
            end
            S_END: begin
                if (out_free) begin
                    emit        = 1'b1;
                    e_kind      = KIND_END;
                    e_len       = r_cmd.total;
                    e_last      = 1'b1;
                    o_disp_done = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_o_valid = emit ? 1'b1 : (i_ready ? 1'b0 : r_o_valid);
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_idx <= n_idx;
        if (emit) begin
            r_kind  <= e_kind;
            r_value <= e_value;
            r_len   <= e_len;
            r_last  <= e_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_kind        = r_kind;
    assign o_value       = r_value;
    assign o_data_length = r_len;
    assign o_last        = r_last;

endmodule
`default_nettype wire

[design/event_stream_line_parser.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// event_stream_line_parser
// Streaming parser for the server-sent events text format, one byte a word.
// ----------------------------------------------------------------------------
// Bytes are taken at up to one per cycle while the two-entry job queue has
// room and no dispatch is in progress; each byte queues at most one job. The
// output side takes one job at a time and sends its result words in turn (a
// data job may send the line feed between data lines ahead of its byte), and
// the input stalls once the queue is full. A blank line that closes an event
// holds the input low until the end word is out: after any jobs already
// queued, the job is taken, each stored event name byte is read and then
// sent, or the default "message" name is sent, and then the end word goes
// out; backpressure on the output delays each of these words.
`include "event_stream_line_parser_assert.svh"

module event_stream_line_parser import eslp_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [7:0]        i_byte_req,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [1:0]             o_kind,
    output logic [7:0]             o_value,
    output logic [DLEN_W-1:0]      o_data_length,
    output logic                   o_last
);

    logic                   w_q_full;
    logic                   w_q_empty;
    logic                   w_q_push;
    logic                   w_q_pop;
    t_cmd                   w_q_cmd;
    t_cmd                   w_q_head;
    logic                   w_we;
    logic [NAME_ADDR_W-1:0] w_waddr;
    logic [7:0]             w_wdata;
    logic                   w_re;
    logic [NAME_ADDR_W-1:0] w_raddr;
    logic [7:0]             w_rdata;
    logic                   w_disp_done;
    logic                   w_busy;

    eslp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_byte_req  (i_byte_req),
        .o_ready     (o_ready),
        .i_q_full    (w_q_full),
        .o_q_push    (w_q_push),
        .o_q_cmd     (w_q_cmd),
        .o_we        (w_we),
        .o_waddr     (w_waddr),
        .o_wdata     (w_wdata),
        .i_disp_done (w_disp_done),
        .o_busy      (w_busy)
    );

    eslp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_cmd   (w_q_cmd),
        .i_pop   (w_q_pop),
        .o_head  (w_q_head),
        .o_full  (w_q_full),
        .o_empty (w_q_empty)
    );

    // event name buffer
    eslp_ram #(
        .WIDTH  (8),
        .DEPTH  (NAME_DEPTH),
        .ADDR_W (NAME_ADDR_W)
    ) u_name_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    eslp_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_head      (w_q_head),
        .i_q_empty     (w_q_empty),
        .o_q_pop       (w_q_pop),
        .o_re          (w_re),
        .o_raddr       (w_raddr),
        .i_rdata       (w_rdata),
        .o_disp_done   (w_disp_done),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_kind        (o_kind),
        .o_value       (o_value),
        .o_data_length (o_data_length),
        .o_last        (o_last)
    );

    `ESLP_ASSERT_IMPLY(a_end_closes, i_clk, i_rst_n, o_valid && o_kind == KIND_END, o_last && o_value == 8'd0, "end word must be last and carry zero value")
    `ESLP_ASSERT_IMPLY(a_len_only_end, i_clk, i_rst_n, o_valid && o_kind != KIND_END, o_data_length == '0, "length set on a non-end word")
    `ESLP_ASSERT_IMPLY(a_busy_stalls, i_clk, i_rst_n, w_busy, !o_ready, "input taken during dispatch")
    `ESLP_ASSERT_NEXT(a_done_frees, i_clk, i_rst_n, w_disp_done, !w_busy, "dispatch end did not release input")

endmodule
`default_nettype wire
